/* src/rmv_pkg.sv */
// Package for the running mean/variance unit: shared types.
// No dependencies.
`timescale 1ns / 1ps

package rmv_pkg;

  // Queue entry between front and back: classified item.
  typedef struct packed {
    logic        clear;
    logic [23:0] sample;
  } rmv_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MEAN_UPD,
    ST_MUL,
    ST_M2_UPD,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } rmv_state_t;

endpackage

/* src/rmv_front.sv */
// Front part: takes items in and holds them in a two-entry queue.
// Depends on rmv_pkg.
`timescale 1ns / 1ps

module rmv_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_WIDTH-1:0]  sample,
  input  logic                     clear,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output rmv_pkg::rmv_cmd_t        cmd
);

  rmv_pkg::rmv_cmd_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].clear  <= clear;
      q[wr_ptr].sample <= 24'($signed(sample));
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/rmv_back.sv */
// Back part: Welford update with serial divider, multiplier and square root.
// Depends on rmv_pkg.
`timescale 1ns / 1ps

module rmv_back #(
  parameter int COUNT_WIDTH    = 24,
  parameter int MEAN_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  rmv_pkg::rmv_cmd_t  cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        sample_count,
  output logic [31:0]        mean_value,
  output logic [39:0]        variance_value,
  output logic [23:0]        std_dev,
  output logic               saturated
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam int Shift = 2 * MEAN_FRAC_BITS - 8;

  rmv_pkg::rmv_state_t state, state_next;

  logic [COUNT_WIDTH-1:0] count;
  logic signed [31:0]     mean_acc;
  logic [63:0]            m2_acc;
  logic                   overflow_flag;

  logic signed [47:0] xs;
  logic signed [47:0] d1;
  logic signed [47:0] d2;
  logic [63:0]        rem;     // divider / sqrt remainder
  logic [63:0]        quo;     // divider quotient / sqrt result
  logic [63:0]        dvd;     // dividend shift register
  logic [6:0]         step;
  logic [127:0]       prod;
  logic [47:0]        mcand;
  logic [47:0]        mplier;
  logic [39:0]        var_r;

  // Shared restoring divider step
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic [COUNT_WIDTH-1:0] divisor;
  always_comb begin
    divisor = (state == rmv_pkg::ST_DIV_VAR) ? count - 1'b1 : count;
    rem_sh  = {rem, dvd[63]};
    rem_sub = rem_sh - {{(65-COUNT_WIDTH){1'b0}}, divisor};
  end

  // sqrt step (digit by digit, two bits each)
  logic [65:0] sq_trial;
  logic [65:0] sq_rem;
  always_comb begin
    sq_rem   = {rem, dvd[63:62]};
    sq_trial = sq_rem - {quo, 2'b01};
  end

  assign cmd_ready = (state == rmv_pkg::ST_IDLE);
  assign out_valid = (state == rmv_pkg::ST_OUT);

  logic signed [48:0] nm;
  logic [63:0] inc;
  logic [127:0] pshift;
  always_comb begin
    nm     = 49'(mean_acc) + (d1[47] ? -49'(quo[47:0]) : 49'(quo[47:0]));
    pshift = prod >> Shift;
    inc    = (pshift[127:64] != 64'd0) ? '1 : pshift[63:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      rmv_pkg::ST_IDLE: if (cmd_valid) begin
        if (cmd.clear || count == CountMax || count == '0) state_next = rmv_pkg::ST_DIV_VAR;
        else state_next = rmv_pkg::ST_DIV_MEAN;
      end
      rmv_pkg::ST_DIV_MEAN: if (step == 7'd63) state_next = rmv_pkg::ST_MEAN_UPD;
      rmv_pkg::ST_MEAN_UPD: state_next = rmv_pkg::ST_MUL;
      rmv_pkg::ST_MUL:      if (step == 7'd47) state_next = rmv_pkg::ST_M2_UPD;
      rmv_pkg::ST_M2_UPD:   state_next = rmv_pkg::ST_DIV_VAR;
      rmv_pkg::ST_DIV_VAR: begin
        if (count < COUNT_WIDTH'(2) || step == 7'd63) state_next = rmv_pkg::ST_SQRT;
      end
      rmv_pkg::ST_SQRT:     if (step == 7'd31) state_next = rmv_pkg::ST_OUT;
      rmv_pkg::ST_OUT:      if (out_ready) state_next = rmv_pkg::ST_IDLE;
      default:              state_next = rmv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rmv_pkg::ST_IDLE;
      count         <= '0;
      mean_acc      <= '0;
      m2_acc        <= '0;
      overflow_flag <= 1'b0;
      step          <= '0;
    end else begin
      state <= state_next;
      case (state)
        rmv_pkg::ST_IDLE: begin
          step <= '0;
          rem  <= '0;
          quo  <= '0;
          if (cmd_valid) begin
            xs <= 48'($signed(cmd.sample)) <<< MEAN_FRAC_BITS;
            if (cmd.clear) begin
              count <= '0; mean_acc <= '0; m2_acc <= '0; overflow_flag <= 1'b0;
              dvd <= '0;
            end else if (count == CountMax) begin
              overflow_flag <= 1'b1;
              dvd <= m2_acc;
            end else if (count == '0) begin
              count    <= COUNT_WIDTH'(1);
              mean_acc <= (48'($signed(cmd.sample)) <<< MEAN_FRAC_BITS > 48'sh7FFFFFFF)
                          ? 32'sh7FFFFFFF
                          : ((48'($signed(cmd.sample)) <<< MEAN_FRAC_BITS) < -48'sh80000000)
                          ? 32'sh80000000
                          : 32'((48'($signed(cmd.sample)) <<< MEAN_FRAC_BITS));
              m2_acc   <= '0;
              dvd      <= '0;
            end else begin
              count <= count + 1'b1;
              d1    <= (48'($signed(cmd.sample)) <<< MEAN_FRAC_BITS) - 48'(mean_acc);
              dvd   <= '0;
            end
          end
        end
        rmv_pkg::ST_DIV_MEAN: begin
          // |d1| / count: |d1| sits in dvd[63:16], 48 steps (16..63)
          if (step == 7'd0) begin
            dvd  <= {(d1[47] ? -d1 : d1), 16'd0};
            rem  <= '0;
            quo  <= '0;
            step <= 7'd16;
          end else begin
            dvd <= dvd << 1;
            if (!rem_sub[64]) begin
              rem <= rem_sub[63:0]; quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh[63:0];  quo <= {quo[62:0], 1'b0};
            end
            step <= step + 1'b1;
          end
        end
        rmv_pkg::ST_MEAN_UPD: begin
          mean_acc <= (nm > 49'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                      (nm < -49'sh80000000) ? 32'sh80000000 : 32'(nm);
          d2     <= xs - 48'((nm > 49'sh7FFFFFFF) ? 49'sh7FFFFFFF :
                      (nm < -49'sh80000000) ? -49'sh80000000 : nm);
          mcand  <= d1[47] ? 48'(-d1) : 48'(d1);
          prod   <= '0;
          step   <= '0;
        end
        rmv_pkg::ST_MUL: begin
          if (step == '0) mplier <= d2[47] ? 48'(-d2) : 48'(d2);
          if (step != '0) begin
            if (mplier[0]) prod <= prod + (128'(mcand) << (step - 1'b1));
            mplier <= mplier >> 1;
          end
          step <= step + 1'b1;
        end
        rmv_pkg::ST_M2_UPD: begin
          if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0))
            m2_acc <= (inc >= m2_acc) ? '0 : m2_acc - inc;
          else
            m2_acc <= (~m2_acc < inc) ? '1 : m2_acc + inc;
          dvd  <= (((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)))
                  ? ((inc >= m2_acc) ? '0 : m2_acc - inc)
                  : ((~m2_acc < inc) ? '1 : m2_acc + inc);
          rem  <= '0;
          quo  <= '0;
          step <= '0;
        end
        rmv_pkg::ST_DIV_VAR: begin
          if (count < COUNT_WIDTH'(2)) begin
            var_r <= '0;
            dvd   <= '0;
            rem   <= '0; quo <= '0; step <= '0;
          end else begin
            dvd <= dvd << 1;
            if (!rem_sub[64]) begin
              rem <= rem_sub[63:0]; quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= rem_sh[63:0];  quo <= {quo[62:0], 1'b0};
            end
            step <= step + 1'b1;
            if (step == 7'd63) begin
              var_r <= ({quo[62:0], !rem_sub[64]} > 64'hFF_FFFF_FFFF) ? '1
                       : 40'({quo[62:0], !rem_sub[64]});
              dvd  <= {({quo[62:0], !rem_sub[64]} > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF
                       : 40'({quo[62:0], !rem_sub[64]}), 8'd0, 16'd0};
              rem  <= '0; quo <= '0; step <= '0;
            end
          end
        end
        rmv_pkg::ST_SQRT: begin
          // 48-bit radicand in dvd[63:16]; steps 0..7 wait, 24 result bits in 8..31
          if (step < 7'd8) begin
            step <= step + 1'b1;
          end else begin
            dvd <= dvd << 2;
            if (!sq_trial[65]) begin
              rem <= sq_trial[63:0]; quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= sq_rem[63:0];   quo <= {quo[62:0], 1'b0};
            end
            step <= step + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign sample_count   = 24'(count);
  assign mean_value     = mean_acc;
  assign variance_value = var_r;
  assign std_dev        = quo[23:0];
  assign saturated      = overflow_flag;

endmodule

/* src/running_mean_variance_unit.sv */
// Top level of the running mean/variance unit.
// Depends on rmv_pkg, rmv_front, rmv_back.
`timescale 1ns / 1ps

//  channel | signals                                     | accepted when
//  in      | in_valid, in_ready, sample, clear           | in_valid & in_ready
//  out     | out_valid, out_ready, sample_count, mean... | out_valid & out_ready
//
// A sample passes through these states in the back part, from taking the
// item to the result being taken: the idle state, a mean division (load
// plus 48 steps), a mean update, a shift-add multiply, an M2 update, a
// 64-step variance division, a square root (8 waiting steps, 24 result
// bits) and the output state. A clear or a first sample runs none of the
// division or multiply steps; a sample dropped at full count runs only the
// variance division and the square root. A stalled result holds the back
// part; the two-entry queue then fills and in_ready drops. rst is
// synchronous and clears the count, mean, M2 and saturation flag.

module running_mean_variance_unit #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COUNT_WIDTH    = 24,
  parameter int MEAN_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    clear,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             sample_count,
  output logic [31:0]             mean_value,
  output logic [39:0]             variance_value,
  output logic [23:0]             std_dev,
  output logic                    saturated
);

  rmv_pkg::rmv_cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  rmv_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .sample, .clear,
    .cmd_valid, .cmd_ready, .cmd
  );

  rmv_back #(.COUNT_WIDTH(COUNT_WIDTH), .MEAN_FRAC_BITS(MEAN_FRAC_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .sample_count, .mean_value,
    .variance_value, .std_dev, .saturated
  );

endmodule

/* src/rmv_checker.sv */
// Port-level checks for the running mean/variance unit, bound to the top.
// Depends on running_mean_variance_unit.
`timescale 1ns / 1ps

module rmv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] sample_count,
  input logic [39:0] variance_value,
  input logic [23:0] std_dev
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(variance_value))
    else $error("result dropped while stalled");

  a_var_low_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_count < 24'd2 |-> variance_value == 40'd0)
    else $error("variance nonzero below two samples");

  a_std_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && variance_value == 40'd0 |-> std_dev == 24'd0)
    else $error("std_dev nonzero with zero variance");

endmodule

bind running_mean_variance_unit rmv_checker u_rmv_checker (
  .clk, .rst, .out_valid, .out_ready, .sample_count, .variance_value, .std_dev
);

/* dv/testbench.sv */
// Testbench for running_mean_variance_unit: directed and random items against
// a built-in Welford predictor. Depends on the RTL under src/.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 800000;
  localparam int HOLD_CYCLES = 3000;
  localparam int N_RANDOM = 480;
  localparam logic [23:0] COUNT_FULL = 24'hffffff;
  localparam logic [39:0] VARIANCE_CAP = 40'hff_ffff_ffff;

  typedef struct {
    logic [23:0] cnt;
    logic [31:0] mean;
    logic [39:0] variance;
    logic [23:0] sd;
    logic        sat;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] sample = '0;
  logic clear = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] sample_count;
  logic [31:0] mean_value;
  logic [39:0] variance_value;
  logic [23:0] std_dev;
  logic saturated;

  int cycles = 0;
  bit quiet = 0;      // no idling on either side
  bit hold_req = 0;   // receiver holds off for a long stretch
  int n_clears = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  running_mean_variance_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .clear(clear),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_count(sample_count), .mean_value(mean_value),
    .variance_value(variance_value), .std_dev(std_dev), .saturated(saturated)
  );

  class stats_board;
    logic [23:0] cnt;
    logic signed [31:0] mean;
    logic [63:0] m2;
    logic flag;
    stats_t awaited[$];
    int errors;

    function new();
      cnt = '0; mean = '0; m2 = '0; flag = 1'b0; errors = 0;
    endfunction

    static function logic [63:0] root(logic [63:0] x);
      logic [63:0] r, b;
      r = '0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function logic signed [31:0] clamp32(longint v);
      if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
      if (v < -longint'(64'sh80000000)) return 32'sh80000000;
      return v[31:0];
    endfunction

    static function logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Welford step on one sample
    function void add(logic [15:0] s);
      longint xs, d1, d2, nm;
      logic [127:0] prod;
      logic [63:0] inc;
      xs = longint'($signed(s)) * 65536;
      if (cnt >= COUNT_FULL) begin
        flag = 1'b1;
        return;
      end
      cnt = cnt + 1;
      if (cnt == 1) begin
        mean = clamp32(xs);
        m2 = '0;
        return;
      end
      d1 = xs - longint'(mean);
      nm = longint'(mean) + d1 / longint'({40'b0, cnt});
      mean = clamp32(nm);
      d2 = xs - longint'(mean);
      prod = 128'(magnitude(d1)) * 128'(magnitude(d2));
      inc = (prod[127:88] != 0) ? '1 : prod[87:24];
      if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0))
        m2 = (inc >= m2) ? '0 : m2 - inc;
      else
        m2 = (~m2 < inc) ? '1 : m2 + inc;
    endfunction

    // accepted input item
    function void note(logic [15:0] s, logic c);
      stats_t e;
      logic [63:0] v;
      if (c) begin
        cnt = '0; mean = '0; m2 = '0; flag = 1'b0;
      end else begin
        add(s);
      end
      v = '0;
      if (cnt > 1) begin
        v = m2 / {40'b0, cnt - 24'd1};
        if (v > {24'b0, VARIANCE_CAP}) v = {24'b0, VARIANCE_CAP};
      end
      e.cnt = cnt;
      e.mean = mean;
      e.variance = v[39:0];
      e.sd = root(v << 8);
      e.sat = flag;
      awaited = {awaited, e};
    endfunction

    function void check(stats_t got);
      stats_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: count %0d", got.cnt);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.cnt !== e.cnt) begin
        $error("sample_count: expected %0d, actual %0d", e.cnt, got.cnt);
        errors++;
      end
      if (got.mean !== e.mean) begin
        $error("mean_value: expected %h, actual %h", e.mean, got.mean);
        errors++;
      end
      if (got.variance !== e.variance) begin
        $error("variance_value: expected %0d, actual %0d", e.variance, got.variance);
        errors++;
      end
      if (got.sd !== e.sd) begin
        $error("std_dev: expected %0d, actual %0d", e.sd, got.sd);
        errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated: expected %0b, actual %0b", e.sat, got.sat);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  stats_board sb = new();

  // results are taken at the edge, from values settled before it
  always @(posedge clk) begin
    stats_t got;
    if (!rst && out_valid && out_ready) begin
      got.cnt = sample_count;
      got.mean = mean_value;
      got.variance = variance_value;
      got.sd = std_dev;
      got.sat = saturated;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one item; called right after the clock rises
  task automatic send_item(logic [15:0] s, logic c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    clear <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(s, c);
    if (c) n_clears++;
  endtask

  // sender pauses; the last item has already been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      3: return 16'(int'($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dir [$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty stats, single sample, extremes, alternation, clears
    send_item(16'h1234, 1'b1);
    dir = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
            16'h8000, 16'h7fff, 16'h5555, 16'haaaa};
    foreach (dir[k]) send_item(dir[k], 1'b0);
    send_item(16'hffff, 1'b1);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(16'h0003, 1'b0);
    send_item(16'hfffd, 1'b0);
    send_item(16'h0003, 1'b0);
    send_item(16'h0000, 1'b0);
    for (int k = 0; k < 6; k++) send_item(k[0] ? 16'h8000 : 16'h7fff, 1'b0);

    // random runs of samples broken by occasional clears
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 100) hold_req = 1;
      if (k == 250) wait_drained();
      if (k == N_RANDOM - 60) quiet = 1;
      if ($urandom_range(0, 24) == 0) send_item(16'($urandom), 1'b1);
      else send_item(pick_sample(), 1'b0);
    end
    in_valid <= 1'b0;
    wait_drained();

    $display("Ran directed extremes and %0d random items, %0d clears, with stalls", N_RANDOM,
             n_clears);
    $display("on both sides, one long output hold-off and one drained pause.");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
